FILE: rtl/secded_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// secded_pkg: shared types and helpers for the 72/64 secded codec
// word layout, command and status codes, position mapping functions
// ----------------------------------------------------------------------------
package secded_pkg;

    localparam int unsigned WORD_BITS = 72;
    localparam int unsigned DATA_BITS = 64;
    localparam int unsigned HEAD_BITS = 8;
    localparam int unsigned SYN_BITS  = 7;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_SINGLE = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef logic [WORD_BITS-1:0] t_word72;   // bit p holds word position p

    typedef struct packed {
        logic                 command;
        logic [DATA_BITS-1:0] data_in;
        logic [HEAD_BITS-1:0] code_head_in;
        logic [DATA_BITS-1:0] code_body_in;
    } t_in_word;

    typedef struct packed {
        logic [DATA_BITS-1:0] data_out;
        logic [HEAD_BITS-1:0] code_head_out;
        logic [DATA_BITS-1:0] code_body_out;
        logic [SYN_BITS-1:0]  syndrome;
        t_status              error_status;
    } t_out_word;

    // position 0 and every power of two are parity / check positions
    function automatic logic is_check_pos(input int unsigned p);
        return (p == 0) || ((p & (p - 1)) == 0);
    endfunction

    // positions whose index has bit k set
    function automatic t_word72 syn_mask(input int unsigned k);
        t_word72 m;
        m = '0;
        for (int unsigned p = 0; p < WORD_BITS; p++) begin
            m[p] = ((p >> k) & 1) != 0;
        end
        return m;
    endfunction

    // head msb is position 0, body msb is position 8
    function automatic t_word72 join_word(input logic [HEAD_BITS-1:0] head,
                                          input logic [DATA_BITS-1:0] body);
        t_word72 w;
        w = '0;
        for (int unsigned p = 0; p < HEAD_BITS; p++) begin
            w[p] = head[HEAD_BITS-1-p];
        end
        for (int unsigned p = HEAD_BITS; p < WORD_BITS; p++) begin
            w[p] = body[WORD_BITS-1-p];
        end
        return w;
    endfunction

    function automatic logic [HEAD_BITS-1:0] word_head(input t_word72 w);
        logic [HEAD_BITS-1:0] h;
        h = '0;
        for (int unsigned p = 0; p < HEAD_BITS; p++) begin
            h[HEAD_BITS-1-p] = w[p];
        end
        return h;
    endfunction

    function automatic logic [DATA_BITS-1:0] word_body(input t_word72 w);
        logic [DATA_BITS-1:0] b;
        b = '0;
        for (int unsigned p = HEAD_BITS; p < WORD_BITS; p++) begin
            b[WORD_BITS-1-p] = w[p];
        end
        return b;
    endfunction

    // data msb goes to the lowest data position, check positions left clear
    function automatic t_word72 place_data(input logic [DATA_BITS-1:0] d);
        t_word72     w;
        int unsigned k;
        w = '0;
        k = 0;
        for (int unsigned p = 0; p < WORD_BITS; p++) begin
            if (!is_check_pos(p)) begin
                w[p] = d[DATA_BITS-1-k];
                k++;
            end
        end
        return w;
    endfunction

    function automatic logic [DATA_BITS-1:0] extract_data(input t_word72 w);
        logic [DATA_BITS-1:0] d;
        int unsigned          k;
        d = '0;
        k = 0;
        for (int unsigned p = 0; p < WORD_BITS; p++) begin
            if (!is_check_pos(p)) begin
                d[DATA_BITS-1-k] = w[p];
                k++;
            end
        end
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/secded_syndrome.sv
`default_nettype none
// ----------------------------------------------------------------------------
// secded_syndrome: syndrome and overall parity of one 72-bit word
// one xor tree per syndrome bit plus one for parity
// ----------------------------------------------------------------------------
module secded_syndrome (
    input  wire secded_pkg::t_word72                  i_word,
    output logic [secded_pkg::SYN_BITS-1:0]           o_syndrome,
    output logic                                      o_parity
);
    import secded_pkg::*;

    for (genvar k = 0; k < SYN_BITS; k++) begin : g_syn
        assign o_syndrome[k] = ^(i_word & syn_mask(k));
    end

    assign o_parity = ^i_word;

endmodule
`default_nettype wire

FILE: rtl/secded_corr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// secded_corr: result builder
// fills check and parity bits on encode, corrects and classifies on decode
// ----------------------------------------------------------------------------
module secded_corr (
    input  wire                                       i_command,
    input  wire [secded_pkg::DATA_BITS-1:0]           i_data,
    input  wire secded_pkg::t_word72                  i_word,
    input  wire [secded_pkg::SYN_BITS-1:0]            i_syndrome,
    input  wire                                       i_parity,
    output secded_pkg::t_out_word                     o_result
);
    import secded_pkg::*;

    t_word72 enc_body;
    t_word72 enc_word;
    t_word72 flip_vec;
    t_word72 dec_word;
    logic    in_range;
    t_status dec_status;

    // encode: syndrome of the bare data word gives the check bits directly
    always_comb begin
        enc_body = i_word;
        for (int unsigned k = 0; k < SYN_BITS; k++) begin
            enc_body[1 << k] = i_syndrome[k];
        end
        enc_word    = enc_body;
        enc_word[0] = ^enc_body;
    end

    // decode: on odd parity flip the in-range syndrome position, 0 if zero
    assign in_range = i_syndrome < SYN_BITS'(WORD_BITS);
    assign flip_vec = (i_parity && in_range) ? (t_word72'(1) << i_syndrome) : '0;
    assign dec_word = i_word ^ flip_vec;

    always_comb begin
        priority if (i_syndrome == '0) begin
            dec_status = i_parity ? ST_SINGLE : ST_CLEAN;
        end else if (!i_parity) begin
            dec_status = ST_DOUBLE;
        end else if (in_range) begin
            dec_status = ST_SINGLE;
        end else begin
            dec_status = ST_RANGE;
        end
    end

    always_comb begin
        if (i_command == CMD_DECODE) begin
            o_result.data_out      = extract_data(dec_word);
            o_result.code_head_out = word_head(dec_word);
            o_result.code_body_out = word_body(dec_word);
            o_result.syndrome      = i_syndrome;
            o_result.error_status  = dec_status;
        end else begin
            o_result.data_out      = i_data;
            o_result.code_head_out = word_head(enc_word);
            o_result.code_body_out = word_body(enc_word);
            o_result.syndrome      = '0;
            o_result.error_status  = ST_CLEAN;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/secded_72_64_codec_core.sv
`default_nettype none
// each word passes through the input register and then the result register before result valid
// throughput: one word per cycle, sustained while the output is not stalled
// the xor trees for syndrome and parity lie on the path from the input register to the result register
// reset: synchronous active low, clears both valid flags; payload regs unreset
// ----------------------------------------------------------------------------
// secded_72_64_codec_core: extended hamming secded encoder / decoder
// 72-bit code words with 64 data bits, single correct, double detect
// ----------------------------------------------------------------------------
module secded_72_64_codec_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // input channel
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire secded_pkg::t_in_word  i_in_word,
    // result channel
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output secded_pkg::t_out_word      o_out_word
);
    import secded_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      n_in_valid;
    // result register
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      n_out_valid;

    logic      out_free;     // result register can take a word this cycle
    logic      in_free;      // input register can take a word this cycle

    t_word72              placed_word;
    t_word72              rx_word;
    t_word72              syn_word;
    logic [SYN_BITS-1:0]  syndrome;
    logic                 parity;
    t_out_word            result;

    // handshake: each register loads when it is empty or being emptied
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_free    = !r_in_valid || out_free;
    assign o_in_stall = !in_free;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (in_free) begin
            n_in_valid = i_in_valid;
        end
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (out_free && r_in_valid) begin
            r_out_word <= result;
        end
    end

    // one syndrome tree serves both commands: on encode it runs over the
    // data-only word and its output is the check bit pattern
    assign placed_word = place_data(r_in_word.data_in);
    assign rx_word     = join_word(r_in_word.code_head_in, r_in_word.code_body_in);
    assign syn_word    = (r_in_word.command == CMD_DECODE) ? rx_word : placed_word;

    secded_syndrome u_syndrome (
        .i_word     (syn_word),
        .o_syndrome (syndrome),
        .o_parity   (parity)
    );

    secded_corr u_corr (
        .i_command  (r_in_word.command),
        .i_data     (r_in_word.data_in),
        .i_word     (syn_word),
        .i_syndrome (syndrome),
        .i_parity   (parity),
        .o_result   (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // a held input word is not dropped while the result side is blocked
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input word lost while result stalled");

    // double error always comes with a nonzero syndrome
    a_double_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.error_status == ST_DOUBLE)
            |-> (o_out_word.syndrome != '0))
        else $error("double error reported with zero syndrome");

    // out of range status only for syndromes past the last position
    a_range_syn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.error_status == ST_RANGE)
            |-> (o_out_word.syndrome >= SYN_BITS'(WORD_BITS)))
        else $error("range status with in-range syndrome");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("valid set after reset");
`endif

endmodule
`default_nettype wire

FILE: verif/secded_72_64_codec_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// secded_72_64_codec_core_test: self-checking bench for the secded codec core
// sends encode and decode words with random idling on both handshakes,
// predicts each result word in the bench and checks the results in order
// ----------------------------------------------------------------------------

localparam int unsigned CW_BITS  = secded_pkg::WORD_BITS;
localparam int unsigned LAST_POS = CW_BITS - 1;

// flat code word {head, body}: bit LAST_POS-p holds word position p
typedef logic [CW_BITS-1:0] t_flat_word;

function automatic bit is_parity_slot(int unsigned p);
    return (p == 0) || ((p & (p - 1)) == 0);
endfunction

function automatic t_flat_word flip_position(t_flat_word cw, int unsigned p);
    return cw ^ (t_flat_word'(1) << (LAST_POS - p));
endfunction

function automatic logic [6:0] syndrome_of(t_flat_word cw);
    logic [6:0] s;
    s = '0;
    for (int unsigned p = 0; p < CW_BITS; p++) begin
        if (cw[LAST_POS - p]) s ^= 7'(p);
    end
    return s;
endfunction

function automatic logic [63:0] data_of(t_flat_word cw);
    logic [63:0] d;
    d = '0;
    for (int unsigned p = 0; p < CW_BITS; p++) begin
        if (!is_parity_slot(p)) d = {d[62:0], cw[LAST_POS - p]};
    end
    return d;
endfunction

function automatic t_flat_word build_codeword(logic [63:0] d);
    t_flat_word  cw;
    logic [6:0]  chk;
    logic [63:0] rest;
    cw   = '0;
    rest = d;
    for (int unsigned p = 0; p < CW_BITS; p++) begin
        if (!is_parity_slot(p)) begin
            cw[LAST_POS - p] = rest[63];
            rest = rest << 1;
        end
    end
    chk = syndrome_of(cw);
    for (int unsigned b = 0; b < 7; b++) begin
        if (chk[b]) cw = flip_position(cw, 1 << b);
    end
    // position 0 is still clear, so this gives even overall parity
    cw[LAST_POS] = ^cw;
    return cw;
endfunction

function automatic secded_pkg::t_out_word codec_result(secded_pkg::t_in_word w);
    secded_pkg::t_out_word r;
    t_flat_word            cw;
    logic [6:0]            syn;
    logic                  odd;
    if (w.command == secded_pkg::CMD_ENCODE) begin
        cw             = build_codeword(w.data_in);
        r.data_out     = w.data_in;
        r.syndrome     = '0;
        r.error_status = secded_pkg::ST_CLEAN;
    end else begin
        cw         = {w.code_head_in, w.code_body_in};
        syn        = syndrome_of(cw);
        odd        = ^cw;
        r.syndrome = syn;
        if (syn == 0) begin
            r.error_status = secded_pkg::ST_CLEAN;
            if (odd) begin
                cw             = flip_position(cw, 0);
                r.error_status = secded_pkg::ST_SINGLE;
            end
        end else if (odd) begin
            if (syn < CW_BITS) begin
                cw             = flip_position(cw, 32'(syn));
                r.error_status = secded_pkg::ST_SINGLE;
            end else begin
                r.error_status = secded_pkg::ST_RANGE;
            end
        end else begin
            r.error_status = secded_pkg::ST_DOUBLE;
        end
        r.data_out = data_of(cw);
    end
    {r.code_head_out, r.code_body_out} = cw;
    return r;
endfunction

class codec_scoreboard;
    secded_pkg::t_out_word expected_words[$];
    int unsigned           mismatches = 0;

    function void note_input(secded_pkg::t_in_word w);
        expected_words.push_back(codec_result(w));
    endfunction

    function void check_result(secded_pkg::t_out_word got);
        secded_pkg::t_out_word want;
        if (expected_words.size() == 0) begin
            $error("result word with none expected: %h", got);
            mismatches++;
        end else begin
            want = expected_words.pop_front();
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                mismatches++;
            end
            if (got.code_head_out !== want.code_head_out) begin
                $error("code_head_out: expected %h, got %h",
                       want.code_head_out, got.code_head_out);
                mismatches++;
            end
            if (got.code_body_out !== want.code_body_out) begin
                $error("code_body_out: expected %h, got %h",
                       want.code_body_out, got.code_body_out);
                mismatches++;
            end
            if (got.syndrome !== want.syndrome) begin
                $error("syndrome: expected %0d, got %0d", want.syndrome, got.syndrome);
                mismatches++;
            end
            if (got.error_status !== want.error_status) begin
                $error("error_status: expected %0d, got %0d",
                       want.error_status, got.error_status);
                mismatches++;
            end
        end
    endfunction
endclass

module secded_72_64_codec_core_test;

    import secded_pkg::*;

    localparam int unsigned RANDOM_WORDS    = 1800;
    localparam int unsigned PHASE_WORDS     = 600;
    localparam int unsigned HOLD_OFF_CYCLES = 64;
    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned DRAIN_CYCLES    = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // idling odds in percent, changed between phases by the stimulus
    int unsigned send_idle_pct  = 23;
    int unsigned recv_stall_pct = 60;
    bit          hold_off_req   = 1'b0;
    int unsigned quiet_cycles   = 0;

    codec_scoreboard sb = new();

    secded_72_64_codec_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin : clock_gen
        forever #6 clk = ~clk;
    end

    // handshake monitor: every accepted word is noted or checked at the edge,
    // and a run of cycles with nothing moving ends the simulation
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_input(in_word);
            if (out_valid && !out_stall) sb.check_result(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // result side: random stalls, or one long hold-off on request so the
    // core backs up and has to stall its input
    initial begin : result_sink
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic t_flat_word random_flat();
        return {8'($urandom), $urandom, $urandom};
    endfunction

    // mostly dense random data, with some all-zero, all-one and one-hot words
    function automatic logic [63:0] random_data();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'(1) << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // flips n distinct positions of a code word
    function automatic t_flat_word inject_errors(t_flat_word cw, int unsigned n_flips);
        t_flat_word  hit;
        int unsigned b;
        hit = '0;
        for (int unsigned k = 0; k < n_flips; k++) begin
            b = $urandom_range(LAST_POS);
            while (hit[b]) b = $urandom_range(LAST_POS);
            hit[b] = 1'b1;
        end
        return cw ^ hit;
    endfunction

    // offer one word, after a random number of idle cycles, and hold it
    // until the core takes it
    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // unused code word fields carry noise, the core must ignore them
    task automatic send_encode(input logic [63:0] d);
        t_in_word w;
        w.command = CMD_ENCODE;
        w.data_in = d;
        {w.code_head_in, w.code_body_in} = random_flat();
        send_word(w);
    endtask

    task automatic send_decode(input t_flat_word cw);
        t_in_word w;
        w.command = CMD_DECODE;
        w.data_in = {$urandom, $urandom};
        {w.code_head_in, w.code_body_in} = cw;
        send_word(w);
    endtask

    task automatic send_random_word();
        int unsigned pick;
        int unsigned n_flips;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_encode(random_data());
        end else if (pick < 90) begin
            // valid code word with zero to three errors
            pick    = $urandom_range(99);
            n_flips = (pick < 15) ? 0 : (pick < 60) ? 1 : (pick < 85) ? 2 : 3;
            send_decode(inject_errors(build_codeword(random_data()), n_flips));
        end else begin
            send_decode(random_flat());
        end
    endtask

    // sender rests until every outstanding result word has come back
    task automatic wait_results_in();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_words.size() != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        t_flat_word base;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: encode extremes
        send_encode('0);
        send_encode('1);
        send_encode(64'h8000_0000_0000_0000);
        send_encode(64'h1);
        send_encode(64'haaaa_aaaa_aaaa_aaaa);
        send_encode(64'h5555_5555_5555_5555);

        // directed: decode of clean words, all-zero and all-one among them
        base = build_codeword(64'h0123_4567_89ab_cdef);
        send_decode('0);
        send_decode('1);
        send_decode(base);

        // single errors: first and last data position, check bits, parity bit
        send_decode(flip_position(base, 3));
        send_decode(flip_position(base, LAST_POS));
        send_decode(flip_position(base, 64));
        send_decode(flip_position(base, 1));
        send_decode(flip_position(base, 0));
        send_decode(flip_position(build_codeword('1), 70));

        // double errors, one of them including the parity bit
        send_decode(flip_position(flip_position(base, 5), 9));
        send_decode(flip_position(flip_position(base, 0), 33));
        send_decode(flip_position(flip_position(base, 71), 56));

        // odd parity with a syndrome past the last position: 72 and 127
        send_decode(flip_position(flip_position(flip_position(base, 64), 8), 0));
        send_decode(flip_position(flip_position(flip_position(base, 71), 56), 0));

        // random words in three idling phases
        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            if (i == PHASE_WORDS) begin
                wait_results_in();
                send_idle_pct  = 60;
                recv_stall_pct = 23;
            end
            if (i == 2 * PHASE_WORDS) begin
                // back-to-back words into a long result hold-off
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_off_req   = 1'b1;
            end
            send_random_word();
        end

        wait_results_in();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: secded_72_64_codec_core.f
rtl/secded_pkg.sv
rtl/secded_syndrome.sv
rtl/secded_corr.sv
rtl/secded_72_64_codec_core.sv
verif/secded_72_64_codec_core_test.sv
